[rtl/hft_pkg.sv]
// hft_pkg: shared constants, types and helpers for the half-edge fan triangulator.
// Used by hft_front, hft_queue, hft_back and the top level; depends on nothing.
package hft_pkg;

  localparam int EDGE_ENTRIES = 4096;
  localparam int EDGE_AW      = $clog2(EDGE_ENTRIES);
  localparam int LOOP_CAP     = 64;
  localparam int LOOP_AW      = $clog2(LOOP_CAP);
  localparam int LEN_W        = $clog2(LOOP_CAP + 1);
  localparam int MIN_LOOP     = 3;
  localparam int QUEUE_DEPTH  = 4;   // power of two
  localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);

  // register indexes on the config port
  localparam logic [1:0] REG_EDGE_TOTAL   = 2'd0;
  localparam logic [1:0] REG_VERTEX_TOTAL = 2'd1;
  localparam logic [1:0] REG_VERTEX_BASE  = 2'd2;

  typedef enum logic {
    CMD_LOAD    = 1'b0,
    CMD_SURFACE = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_PRIME,
    ST_LOADB,
    ST_SHOW
  } state_t;

  typedef struct packed {
    logic [12:0] edge_total;
    logic [15:0] vertex_total;
    logic [31:0] vertex_base;
  } cfg_t;

  typedef struct packed {
    cmd_t               kind;
    logic [EDGE_AW-1:0] slot;
    logic [31:0]        vword;    // {end, start}
    logic [47:0]        lword;    // {left, reverse, forward}
    logic [15:0]        surface;
    logic [EDGE_AW-1:0] start;
  } job_t;

  // edge_total saturated to the table depth
  function automatic logic [EDGE_AW:0] eff_edges(input logic [12:0] total);
    logic [EDGE_AW:0] r;
    if (int'(total) > EDGE_ENTRIES) r = (EDGE_AW + 1)'(EDGE_ENTRIES);
    else r = (EDGE_AW + 1)'(total);
    return r;
  endfunction

endpackage

[rtl/hft_front.sv]
// hft_front: accepts input beats, drops those that give no result, packs the rest as jobs.
// Depends on hft_pkg.
module hft_front (
  input  logic               push,
  output logic               full,
  input  logic               cmd,
  input  logic [11:0]        edge_slot,
  input  logic signed [15:0] start_vertex,
  input  logic signed [15:0] end_vertex,
  input  logic signed [15:0] forward_link,
  input  logic signed [15:0] reverse_link,
  input  logic signed [15:0] left_face,
  input  logic [15:0]        surface_number,
  input  logic [15:0]        first_edge,
  input  logic               hidden,
  input  hft_pkg::cfg_t      cfg,
  input  logic               q_full,
  output logic               q_push,
  output hft_pkg::job_t      job
);

  logic [hft_pkg::EDGE_AW:0] edges;
  logic                      keep;

  assign edges = hft_pkg::eff_edges(cfg.edge_total);

  always_comb begin
    if (hft_pkg::cmd_t'(cmd) == hft_pkg::CMD_LOAD) begin
      keep = int'(edge_slot) < hft_pkg::EDGE_ENTRIES;
    end else begin
      keep = !hidden && (32'(first_edge) < 32'(edges));
    end
  end

  assign full   = q_full;
  assign q_push = push && !q_full && keep;

  assign job.kind    = hft_pkg::cmd_t'(cmd);
  assign job.slot    = hft_pkg::EDGE_AW'(edge_slot);
  assign job.vword   = {end_vertex, start_vertex};
  assign job.lword   = {left_face, reverse_link, forward_link};
  assign job.surface = surface_number;
  assign job.start   = hft_pkg::EDGE_AW'(first_edge);

endmodule

[rtl/hft_queue.sv]
// hft_queue: short job queue between the front and the back.
// Depends on hft_pkg.
module hft_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  hft_pkg::job_t wdata,
  input  logic          pop,
  output logic          full,
  output logic          empty,
  output hft_pkg::job_t head
);

  hft_pkg::job_t                 slots [hft_pkg::QUEUE_DEPTH];
  logic [hft_pkg::QUEUE_AW-1:0]  wptr;
  logic [hft_pkg::QUEUE_AW-1:0]  rptr;
  logic [hft_pkg::QUEUE_AW:0]    count;
  logic                          do_push;
  logic                          do_pop;

  assign full    = count == (hft_pkg::QUEUE_AW + 1)'(hft_pkg::QUEUE_DEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= wptr + 1'b1;
      if (do_pop) rptr <= rptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wptr] <= wdata;
  end

  assert property (@(posedge clk) disable iff (rst)
    count <= (hft_pkg::QUEUE_AW + 1)'(hft_pkg::QUEUE_DEPTH))
    else $error("queue count over depth");

  assert property (@(posedge clk) disable iff (rst)
    do_push && !do_pop |=> !empty)
    else $error("queue empty after a push");

  assert property (@(posedge clk) disable iff (rst)
    (count == '0) == (wptr == rptr) || full)
    else $error("queue pointers disagree with count");

endmodule

[rtl/hft_back.sv]
// hft_back: edge table, loop walk, loop vertex memory and fan emitter with output register.
// Depends on hft_pkg.
module hft_back (
  input  logic          clk,
  input  logic          rst,
  input  hft_pkg::cfg_t cfg,
  input  logic          q_empty,
  input  hft_pkg::job_t head,
  output logic          q_pop,
  input  logic          pop,
  output logic          empty,
  output logic [31:0]   corner_a,
  output logic [31:0]   corner_b,
  output logic [31:0]   corner_c,
  output logic          final_triangle
);

  localparam int AW = hft_pkg::EDGE_AW;
  localparam int LW = hft_pkg::LEN_W;
  localparam int VW = hft_pkg::LOOP_AW;

  logic [31:0]   edge_vertex_store [hft_pkg::EDGE_ENTRIES];
  logic [47:0]   edge_link_store   [hft_pkg::EDGE_ENTRIES];
  logic [14:0]   loop_vertices     [hft_pkg::LOOP_CAP];

  hft_pkg::state_t state, state_next;
  logic [AW-1:0] walk_edge;
  logic [AW-1:0] start_edge;
  logic [15:0]   surface;
  logic [LW-1:0] loop_length;
  logic [LW-1:0] idx;
  logic [14:0]   apex;
  logic [14:0]   prev;
  logic          out_valid;
  logic [31:0]   vq;
  logic [47:0]   lq;
  logic [14:0]   lv_q;

  logic [AW:0]   edges;
  logic [AW-1:0] edge_raddr;
  logic [VW-1:0] lv_raddr;
  logic          edge_we;
  logic          walk_take;
  logic          match;
  logic [15:0]   vtx;
  logic [15:0]   nxt;
  logic [AW-1:0] nxt_e;
  logic          vtx_ok;
  logic          nxt_ok;
  logic          walk_more;
  logic [LW-1:0] len_inc;
  logic          load_out;
  logic          last_tri;

  assign edges = hft_pkg::eff_edges(cfg.edge_total);

  // left face is signed, surface number is not: a negative face never matches
  assign match     = !lq[47] && (lq[47:32] == surface);
  assign vtx       = match ? vq[15:0] : vq[31:16];
  assign nxt       = match ? lq[15:0] : lq[31:16];
  assign vtx_ok    = !vtx[15] && (vtx < cfg.vertex_total);
  assign nxt_ok    = !nxt[15] && ({1'b0, nxt} < 17'(edges));
  assign nxt_e     = AW'(nxt);
  assign len_inc   = loop_length + LW'(1);
  assign walk_more = nxt_ok && (nxt_e != start_edge) && (len_inc < LW'(hft_pkg::LOOP_CAP));
  assign load_out  = (state == hft_pkg::ST_SHOW) && (!out_valid || pop);
  assign last_tri  = (idx + LW'(1)) == loop_length;
  assign edge_we   = (state == hft_pkg::ST_IDLE) && !q_empty && (head.kind == hft_pkg::CMD_LOAD);
  assign walk_take = (state == hft_pkg::ST_IDLE) && !q_empty && (head.kind == hft_pkg::CMD_SURFACE);

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    edge_raddr = head.start;
    lv_raddr   = VW'(idx);
    unique case (state)
      hft_pkg::ST_IDLE: begin
        q_pop = !q_empty;
        if (walk_take) state_next = hft_pkg::ST_WALK;
      end
      hft_pkg::ST_WALK: begin
        edge_raddr = nxt_e;
        if (!vtx_ok) begin
          state_next = (loop_length >= LW'(hft_pkg::MIN_LOOP)) ? hft_pkg::ST_PRIME
                                                                : hft_pkg::ST_IDLE;
        end else if (!walk_more) begin
          state_next = (len_inc >= LW'(hft_pkg::MIN_LOOP)) ? hft_pkg::ST_PRIME
                                                            : hft_pkg::ST_IDLE;
        end
      end
      hft_pkg::ST_PRIME: begin
        lv_raddr   = VW'(1);
        state_next = hft_pkg::ST_LOADB;
      end
      hft_pkg::ST_LOADB: begin
        lv_raddr   = VW'(2);
        state_next = hft_pkg::ST_SHOW;
      end
      hft_pkg::ST_SHOW: begin
        // fetch the next vertex only when this triangle moves out
        if (load_out) begin
          lv_raddr = VW'(idx + LW'(1));
          if (last_tri) state_next = hft_pkg::ST_IDLE;
        end
      end
      default: state_next = hft_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= hft_pkg::ST_IDLE;
      walk_edge   <= '0;
      loop_length <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (walk_take) begin
        walk_edge   <= head.start;
        loop_length <= '0;
      end
      if (state == hft_pkg::ST_WALK && vtx_ok) begin
        loop_length <= len_inc;
        if (walk_more) walk_edge <= nxt_e;
      end
      if (load_out) out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (walk_take) begin
      start_edge <= head.start;
      surface    <= head.surface;
    end
    if (state == hft_pkg::ST_WALK && vtx_ok && loop_length == '0) apex <= vtx[14:0];
    if (state == hft_pkg::ST_LOADB) begin
      prev <= lv_q;
      idx  <= LW'(2);
    end
    if (load_out) begin
      prev           <= lv_q;
      idx            <= idx + LW'(1);
      corner_a       <= cfg.vertex_base + 32'(apex);
      corner_b       <= cfg.vertex_base + 32'(prev);
      corner_c       <= cfg.vertex_base + 32'(lv_q);
      final_triangle <= last_tri;
    end
  end

  always_ff @(posedge clk) begin
    if (edge_we) begin
      edge_vertex_store[head.slot] <= head.vword;
      edge_link_store[head.slot]   <= head.lword;
    end
    vq <= edge_vertex_store[edge_raddr];
    lq <= edge_link_store[edge_raddr];
  end

  always_ff @(posedge clk) begin
    if (state == hft_pkg::ST_WALK && vtx_ok) loop_vertices[VW'(loop_length)] <= vtx[14:0];
    lv_q <= loop_vertices[lv_raddr];
  end

  assign empty = !out_valid;

  assert property (@(posedge clk) disable iff (rst)
    loop_length <= LW'(hft_pkg::LOOP_CAP))
    else $error("loop length over cap");

  assert property (@(posedge clk) disable iff (rst)
    state == hft_pkg::ST_WALK |-> {1'b0, walk_edge} < edges)
    else $error("walk edge out of range");

  assert property (@(posedge clk) disable iff (rst)
    state == hft_pkg::ST_SHOW |-> loop_length >= LW'(hft_pkg::MIN_LOOP) && idx < loop_length)
    else $error("emit index outside loop");

  assert property (@(posedge clk) disable iff (rst)
    load_out && last_tri |=> state == hft_pkg::ST_IDLE && out_valid && final_triangle)
    else $error("last triangle not closing the surface");

endmodule

[rtl/half_edge_surface_fan_triangulator.sv]
// half_edge_surface_fan_triangulator: top level with config registers, front, queue and back.
// Depends on hft_pkg, hft_front, hft_queue, hft_back.
//
//   port group        dir   handshake         payload
//   input items       in    push / full       cmd, edge_slot .. hidden
//   triangles         out   pop / empty       corner_a, corner_b, corner_c, final_triangle
//   config            in    APB write/read    edge_total, vertex_total, vertex_base
//
// Load beats and dropped surfaces pass the combinational front; the back writes the loads.
// A surface walks one edge per cycle (edge table read port), then ST_PRIME and ST_LOADB
// prime the fan, which emits one triangle per cycle unless stalled: L - 2 for L vertices.
// Reset is synchronous; no clearing pass, the stores are undefined until written.
// A stalled triangle holds the back; the front keeps taking beats until the queue fills.
module half_edge_surface_fan_triangulator (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               push,
  output logic               full,
  input  logic               cmd,
  input  logic [11:0]        edge_slot,
  input  logic signed [15:0] start_vertex,
  input  logic signed [15:0] end_vertex,
  input  logic signed [15:0] forward_link,
  input  logic signed [15:0] reverse_link,
  input  logic signed [15:0] left_face,
  input  logic [15:0]        surface_number,
  input  logic [15:0]        first_edge,
  input  logic               hidden,
  output logic               empty,
  input  logic               pop,
  output logic [31:0]        corner_a,
  output logic [31:0]        corner_b,
  output logic [31:0]        corner_c,
  output logic               final_triangle
);

  hft_pkg::cfg_t cfg;
  hft_pkg::job_t job;
  hft_pkg::job_t head;
  logic          q_push;
  logic          q_pop;
  logic          q_full;
  logic          q_empty;
  logic          cfg_we;
  logic [1:0]    reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.edge_total   <= '0;
      cfg.vertex_total <= '0;
      cfg.vertex_base  <= '0;
    end else if (cfg_we) begin
      case (reg_idx)
        hft_pkg::REG_EDGE_TOTAL:   cfg.edge_total   <= pwdata[12:0];
        hft_pkg::REG_VERTEX_TOTAL: cfg.vertex_total <= pwdata[15:0];
        hft_pkg::REG_VERTEX_BASE:  cfg.vertex_base  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      hft_pkg::REG_EDGE_TOTAL:   prdata = 32'(cfg.edge_total);
      hft_pkg::REG_VERTEX_TOTAL: prdata = 32'(cfg.vertex_total);
      hft_pkg::REG_VERTEX_BASE:  prdata = cfg.vertex_base;
      default:                   prdata = '0;
    endcase
  end

  hft_front u_front (
    .push           (push),
    .full           (full),
    .cmd            (cmd),
    .edge_slot      (edge_slot),
    .start_vertex   (start_vertex),
    .end_vertex     (end_vertex),
    .forward_link   (forward_link),
    .reverse_link   (reverse_link),
    .left_face      (left_face),
    .surface_number (surface_number),
    .first_edge     (first_edge),
    .hidden         (hidden),
    .cfg            (cfg),
    .q_full         (q_full),
    .q_push         (q_push),
    .job            (job)
  );

  hft_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (job),
    .pop   (q_pop),
    .full  (q_full),
    .empty (q_empty),
    .head  (head)
  );

  hft_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .q_empty        (q_empty),
    .head           (head),
    .q_pop          (q_pop),
    .pop            (pop),
    .empty          (empty),
    .corner_a       (corner_a),
    .corner_b       (corner_b),
    .corner_c       (corner_c),
    .final_triangle (final_triangle)
  );

endmodule
